[src/uftr_pkg.sv]
`timescale 1ns / 1ps

package uftr_pkg;

   // Input action codes.
   localparam logic [1:0] ACT_RX_BYTE   = 2'd0;
   localparam logic [1:0] ACT_HOST_BYTE = 2'd1;
   localparam logic [1:0] ACT_TX_TICK   = 2'd2;

   // Result kinds.
   localparam logic [2:0] KIND_NONE     = 3'd0;
   localparam logic [2:0] KIND_PAYLOAD  = 3'd1;
   localparam logic [2:0] KIND_STATUS   = 3'd2;
   localparam logic [2:0] KIND_TX_BYTE  = 3'd3;
   localparam logic [2:0] KIND_TX_IDLE  = 3'd4;
   localparam logic [2:0] KIND_EMPTY    = 3'd5;

   // Push status codes.
   localparam logic [1:0] PUSH_OK       = 2'd0;
   localparam logic [1:0] PUSH_BAD_LEN  = 2'd1;
   localparam logic [1:0] PUSH_OVERFLOW = 2'd2;

   // Acknowledge reply: "ACK" CR LF.
   localparam int unsigned ACK_LEN   = 5;
   localparam int unsigned ACK_IDX_W = $clog2(ACK_LEN);

   function automatic logic [7:0] ack_byte(input logic [ACK_IDX_W-1:0] idx);
      logic [7:0] b;
      case (idx)
         3'd0:    b = 8'h41;
         3'd1:    b = 8'h43;
         3'd2:    b = 8'h4B;
         3'd3:    b = 8'h0D;
         3'd4:    b = 8'h0A;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   // Controller states.
   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_PRE  = 6'b000010,
      ST_EXEC = 6'b000100,
      ST_ACK  = 6'b001000,
      ST_READ = 6'b010000,
      ST_OUT  = 6'b100000
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic pre;
      logic exec;
      logic ack_write;
      logic read_done;
      logic load_out;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic pre_go;
      logic exec_go;
      logic read_req;
      logic ack_last;
      logic out_free;
   } dp_status_type;

endpackage

[src/uftr_ram.sv]
`timescale 1ns / 1ps

module uftr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/uftr_ctrl.sv]
`timescale 1ns / 1ps

module uftr_ctrl import uftr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   ctrl_state_type state_ff, state_in;
   logic           ret_exec_ff, ret_exec_in;

   // Sequencer: pre-flush, main operation, reply write or ring read, result hand-off.
   always_comb begin
      state_in    = state_ff;
      ret_exec_in = ret_exec_ff;
      cmd         = '0;
      req_tready  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_PRE;
            end
         end
         ST_PRE: begin
            cmd.pre = 1'b1;
            if (status.pre_go) begin
               ret_exec_in = 1'b1;
               state_in    = ST_ACK;
            end else begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            if (status.read_req) begin
               state_in = ST_READ;
            end else if (status.exec_go) begin
               ret_exec_in = 1'b0;
               state_in    = ST_ACK;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_ACK: begin
            cmd.ack_write = 1'b1;
            if (status.ack_last) begin
               state_in = ret_exec_ff ? ST_EXEC : ST_OUT;
            end
         end
         ST_READ: begin
            cmd.read_done = 1'b1;
            state_in      = ST_OUT;
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         ret_exec_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         ret_exec_ff <= ret_exec_in;
      end
   end

endmodule

[src/uftr_dp.sv]
`timescale 1ns / 1ps

module uftr_dp import uftr_pkg::*; #(
   parameter int TX_DEPTH = 64
) (
   input  logic          clock,
   input  logic          reset,
   input  ctrl_cmd_type  cmd,
   output dp_status_type status,
   input  logic [1:0]    in_action,
   input  logic [7:0]    in_data_byte,
   input  logic          in_msg_first,
   input  logic [7:0]    in_msg_len,
   input  logic          rsp_tready,
   output logic          rsp_valid,
   output logic [2:0]    rsp_kind,
   output logic [7:0]    rsp_byte,
   output logic          rsp_last,
   output logic [1:0]    rsp_status
);

   localparam int PTR_W = $clog2(TX_DEPTH);
   localparam int CNT_W = $clog2(TX_DEPTH + 1);
   localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

   // Captured item.
   logic [1:0] act_ff, act_in;
   logic [7:0] dat_ff, dat_in;
   logic       first_ff, first_in;
   logic [7:0] len_ff, len_in;

   // Link state.
   logic [PTR_W-1:0]     head_ff, head_in;
   logic [PTR_W-1:0]     tail_ff, tail_in;
   logic                 rx_in_ff, rx_in_in;
   logic [7:0]           rx_rem_ff, rx_rem_in;
   logic                 ack_ff, ack_in;
   logic [7:0]           host_left_ff, host_left_in;
   logic                 drop_ff, drop_in;
   logic [ACK_IDX_W-1:0] ack_idx_ff, ack_idx_in;

   // Result being built, and the output register.
   logic [2:0] res_kind_ff, res_kind_in;
   logic [7:0] res_byte_ff, res_byte_in;
   logic       res_last_ff, res_last_in;
   logic [1:0] res_stat_ff, res_stat_in;
   logic       out_valid_ff, out_valid_in;
   logic [2:0] out_kind_ff, out_kind_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       out_last_ff, out_last_in;
   logic [1:0] out_stat_ff, out_stat_in;

   // Ring port signals.
   logic             ram_we;
   logic [PTR_W-1:0] ram_waddr;
   logic [7:0]       ram_wdata;
   logic             ram_re;
   logic [7:0]       ram_rdata;

   // Occupancy.
   logic [CNT_W-1:0] used, free_cnt;
   logic [CMP_W-1:0] free_c;
   logic             admitting;
   logic             pre_req;
   logic             ack_eff;

   // Main operation decode.
   logic [2:0] ex_kind;
   logic [7:0] ex_byte;
   logic       ex_last;
   logic [1:0] ex_stat;
   logic       ex_put, ex_read, ex_post, ex_hdr;
   logic       ex_rx_in;
   logic [7:0] ex_rx_rem;
   logic [7:0] ex_host_left;
   logic       ex_drop;
   logic       ex_room;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(TX_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   // Ring fill level and free slots.
   always_comb begin
      if (head_ff >= tail_ff) begin
         used = CNT_W'(head_ff) - CNT_W'(tail_ff);
      end else begin
         used = CNT_W'(head_ff) + CNT_W'(TX_DEPTH) - CNT_W'(tail_ff);
      end
      free_cnt  = CNT_W'(TX_DEPTH - 1) - used;
      free_c    = CMP_W'(free_cnt);
      admitting = (host_left_ff != 8'd0) && !drop_ff;
      pre_req   = (act_ff == ACT_HOST_BYTE) && first_ff;
   end

   // Decode of the main operation for the captured item.
   always_comb begin
      ex_kind      = KIND_NONE;
      ex_byte      = 8'd0;
      ex_last      = 1'b0;
      ex_stat      = PUSH_OK;
      ex_put       = 1'b0;
      ex_read      = 1'b0;
      ex_post      = 1'b0;
      ex_hdr       = 1'b0;
      ex_rx_in     = rx_in_ff;
      ex_rx_rem    = rx_rem_ff;
      ex_host_left = host_left_ff;
      ex_drop      = drop_ff;
      case (act_ff)
         ACT_RX_BYTE: begin
            if (!rx_in_ff) begin
               ex_hdr    = 1'b1;
               ex_rx_rem = dat_ff;
               ex_post   = !admitting;
               if (dat_ff == 8'd0) begin
                  ex_kind = KIND_EMPTY;
               end else begin
                  ex_rx_in = 1'b1;
               end
            end else begin
               ex_kind = KIND_PAYLOAD;
               ex_byte = dat_ff;
               if (rx_rem_ff <= 8'd1) begin
                  ex_last   = 1'b1;
                  ex_rx_rem = 8'd0;
                  ex_rx_in  = 1'b0;
               end else begin
                  ex_rx_rem = rx_rem_ff - 8'd1;
               end
            end
         end
         ACT_HOST_BYTE: begin
            if (first_ff) begin
               ex_kind      = KIND_STATUS;
               ex_host_left = 8'd0;
               ex_drop      = 1'b0;
               if (len_ff == 8'd0) begin
                  ex_stat = PUSH_BAD_LEN;
               end else if (CMP_W'(len_ff) > free_c) begin
                  ex_stat      = PUSH_OVERFLOW;
                  ex_host_left = len_ff - 8'd1;
                  ex_drop      = (len_ff != 8'd1);
               end else begin
                  ex_put       = 1'b1;
                  ex_host_left = len_ff - 8'd1;
                  ex_post      = (len_ff == 8'd1);
               end
            end else if (host_left_ff != 8'd0) begin
               ex_host_left = host_left_ff - 8'd1;
               if (drop_ff) begin
                  if (host_left_ff == 8'd1) begin
                     ex_drop = 1'b0;
                  end
               end else begin
                  ex_put  = 1'b1;
                  ex_post = (host_left_ff == 8'd1);
               end
            end
         end
         ACT_TX_TICK: begin
            if (head_ff != tail_ff) begin
               ex_kind = KIND_TX_BYTE;
               ex_read = 1'b1;
            end else begin
               ex_kind = KIND_TX_IDLE;
            end
         end
         default: begin
            ex_kind = KIND_NONE;
         end
      endcase
      ex_room = free_c >= (CMP_W'(ACK_LEN) + CMP_W'(ex_put));
   end

   assign ack_eff = ex_hdr || ack_ff;

   // Status to the controller.
   always_comb begin
      status.pre_go   = pre_req && ack_ff && (free_c >= CMP_W'(ACK_LEN));
      status.exec_go  = ex_post && ack_eff && ex_room;
      status.read_req = ex_read;
      status.ack_last = (ack_idx_ff == ACK_IDX_W'(ACK_LEN - 1));
      status.out_free = !out_valid_ff || rsp_tready;
   end

   // Next state of every register, by command.
   always_comb begin
      act_in       = act_ff;
      dat_in       = dat_ff;
      first_in     = first_ff;
      len_in       = len_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      rx_in_in     = rx_in_ff;
      rx_rem_in    = rx_rem_ff;
      ack_in       = ack_ff;
      host_left_in = host_left_ff;
      drop_in      = drop_ff;
      ack_idx_in   = ack_idx_ff;
      res_kind_in  = res_kind_ff;
      res_byte_in  = res_byte_ff;
      res_last_in  = res_last_ff;
      res_stat_in  = res_stat_ff;
      out_valid_in = out_valid_ff;
      out_kind_in  = out_kind_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      out_stat_in  = out_stat_ff;
      ram_we       = 1'b0;
      ram_waddr    = head_ff;
      ram_wdata    = dat_ff;
      ram_re       = 1'b0;

      if (cmd.capture) begin
         act_in   = in_action;
         dat_in   = in_data_byte;
         first_in = in_msg_first;
         len_in   = in_msg_len;
      end

      // A new host message first settles any pending reply.
      if (cmd.pre && pre_req) begin
         ack_in = 1'b0;
      end

      if (cmd.exec) begin
         rx_in_in     = ex_rx_in;
         rx_rem_in    = ex_rx_rem;
         host_left_in = ex_host_left;
         drop_in      = ex_drop;
         ack_in       = ack_eff && !ex_post;
         res_kind_in  = ex_kind;
         res_byte_in  = ex_byte;
         res_last_in  = ex_last;
         res_stat_in  = ex_stat;
         if (ex_put) begin
            ram_we  = 1'b1;
            head_in = ptr_inc(head_ff);
         end
         if (ex_read) begin
            ram_re  = 1'b1;
            tail_in = ptr_inc(tail_ff);
         end
      end

      // Reply bytes go into the ring one per cycle.
      if (cmd.ack_write) begin
         ram_we    = 1'b1;
         ram_wdata = ack_byte(ack_idx_ff);
         head_in   = ptr_inc(head_ff);
         ack_idx_in = status.ack_last ? '0 : ack_idx_ff + 1'b1;
      end

      if (cmd.read_done) begin
         res_byte_in = ram_rdata;
      end

      // Output register: loaded when free, cleared when its transfer completes.
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
         out_kind_in  = res_kind_ff;
         out_byte_in  = res_byte_ff;
         out_last_in  = res_last_ff;
         out_stat_in  = res_stat_ff;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         rx_in_ff     <= 1'b0;
         rx_rem_ff    <= 8'd0;
         ack_ff       <= 1'b0;
         host_left_ff <= 8'd0;
         drop_ff      <= 1'b0;
         ack_idx_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         rx_in_ff     <= rx_in_in;
         rx_rem_ff    <= rx_rem_in;
         ack_ff       <= ack_in;
         host_left_ff <= host_left_in;
         drop_ff      <= drop_in;
         ack_idx_ff   <= ack_idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      dat_ff      <= dat_in;
      first_ff    <= first_in;
      len_ff      <= len_in;
      res_kind_ff <= res_kind_in;
      res_byte_ff <= res_byte_in;
      res_last_ff <= res_last_in;
      res_stat_ff <= res_stat_in;
      out_kind_ff <= out_kind_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
      out_stat_ff <= out_stat_in;
   end

   uftr_ram #(
      .WIDTH (8),
      .DEPTH (TX_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (tail_ff),
      .rd_data (ram_rdata)
   );

   assign rsp_valid  = out_valid_ff;
   assign rsp_kind   = out_kind_ff;
   assign rsp_byte   = out_byte_ff;
   assign rsp_last   = out_last_ff;
   assign rsp_status = out_stat_ff;

endmodule

[src/uart_frame_receiver_with_tx_ring.sv]
`timescale 1ns / 1ps

// Channel   Direction  Ports        Contents
// req       in         req_t*       tdata: data_byte, msg_len; tuser: action, msg_first
// rsp       out        rsp_t*       tdata: byte_out, push_status; tuser: result_kind;
//                                   tlast: frame_last
//
// One item at a time: an item passes through the idle, prepare, execute and output
// states. A ring read adds a read state (registered read port of the transmit ring), and
// an ACK reply adds an ack state that writes the reply one byte per cycle on the ring's
// single write port.
// Reset is synchronous; it empties the ring and clears the framing state.
// A result waits in the output register while the next item is taken; only
// when that register is still full at the end of an item does the block stall.

module uart_frame_receiver_with_tx_ring import uftr_pkg::*; #(
   parameter int TX_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] data_byte, [15:8] msg_len
   input  logic [2:0]  req_tuser,   // [1:0] action, [2] msg_first
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] byte_out, [9:8] push_status, [15:10] zero
   output logic [2:0]  rsp_tuser,   // [2:0] result_kind
   output logic        rsp_tlast
);

   ctrl_cmd_type  cmd;
   dp_status_type status;
   logic [7:0]    rsp_byte;
   logic [1:0]    rsp_status;

   uftr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   uftr_dp #(
      .TX_DEPTH (TX_DEPTH)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .in_action    (req_tuser[1:0]),
      .in_data_byte (req_tdata[7:0]),
      .in_msg_first (req_tuser[2]),
      .in_msg_len   (req_tdata[15:8]),
      .rsp_tready   (rsp_tready),
      .rsp_valid    (rsp_tvalid),
      .rsp_kind     (rsp_tuser),
      .rsp_byte     (rsp_byte),
      .rsp_last     (rsp_tlast),
      .rsp_status   (rsp_status)
   );

   assign rsp_tdata = {6'd0, rsp_status, rsp_byte};

endmodule

[src/uftr_chk.sv]
`timescale 1ns / 1ps

module uftr_chk import uftr_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [15:0] req_tdata,
   input logic [2:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [2:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // A stalled result holds its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)
         && $stable(rsp_tlast))
      else $error("stalled result changed");

   // An offered item that waits keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid && $stable(req_tdata) && $stable(req_tuser))
      else $error("waiting input item changed");

   // Items are worked one at a time: no transfer right after a transfer.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken while an item is in progress");

   // The frame mark only rides on payload bytes.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser == KIND_PAYLOAD)
      else $error("frame mark on a non-payload result");

   // Status only on push results, byte only on payload and transmit results.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[9:8] == PUSH_OK || rsp_tuser == KIND_STATUS)
         && (rsp_tdata[7:0] == 8'd0 || rsp_tuser == KIND_PAYLOAD
             || rsp_tuser == KIND_TX_BYTE)
         && rsp_tdata[15:10] == 6'd0)
      else $error("result fields do not match its kind");

endmodule

bind uart_frame_receiver_with_tx_ring uftr_chk u_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

[test/uart_frame_receiver_with_tx_ring_test.sv]
`timescale 1ns / 1ps

module uart_frame_receiver_with_tx_ring_test;
   import uftr_pkg::*;

   // Action code the block does not define; it must be ignored.
   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam int unsigned RING_SLOTS = 64;
   localparam logic [7:0] ACK_TEXT [ACK_LEN] = '{8'h41, 8'h43, 8'h4B, 8'h0D, 8'h0A};

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] data_out;
      logic       frame_end;
      logic [1:0] status;
   } link_result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // [7:0] data_byte, [15:8] msg_len
   logic [2:0]  req_tuser;   // [1:0] action, [2] msg_first
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;   // [7:0] byte_out, [9:8] push_status, [15:10] zero
   logic [2:0]  rsp_tuser;   // [2:0] result_kind
   logic        rsp_tlast;

   // Predicted link-layer state.
   logic [7:0]   tx_ring [RING_SLOTS];
   logic [5:0]   ring_wr;
   logic [5:0]   ring_rd;
   logic         frame_open;
   logic [7:0]   frame_left;
   logic         ack_owed;
   logic [7:0]   msg_left;
   logic         msg_refused;

   // Results still owed by the block, oldest first.
   link_result_type awaited_results [$];
   int           error_count = 0;
   int           sender_idle_pct = 0;
   int           rsp_stall_pct = 0;

   // Sequence tracking for the random traffic generator.
   logic [7:0]   gen_frame_left = 8'd0;
   logic [7:0]   gen_msg_left = 8'd0;

   uart_frame_receiver_with_tx_ring i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Free slots in the ring; one slot always stays empty.
   function automatic int unsigned ring_room();
      logic [5:0] used;
      used = ring_wr - ring_rd;
      return RING_SLOTS - 1 - int'(used);
   endfunction

   task automatic ring_push(input logic [7:0] value);
      tx_ring[ring_wr] = value;
      ring_wr = ring_wr + 6'd1;
   endtask

   // Write the owed ACK reply if it fits, otherwise drop it.
   task automatic flush_ack();
      if (ack_owed) begin
         ack_owed = 1'b0;
         if (ring_room() >= ACK_LEN) begin
            for (int i = 0; i < ACK_LEN; i++) ring_push(ACK_TEXT[i]);
         end
      end
   endtask

   // Advance the predicted state by one item and queue the result it causes.
   task automatic predict_link_result(input logic [1:0] action, input logic [7:0] data,
                                      input logic first, input logic [7:0] len);
      link_result_type res;
      res = '0;
      res.kind = KIND_NONE;
      res.status = PUSH_OK;
      case (action)
         ACT_RX_BYTE: begin
            if (!frame_open) begin
               // A header opens a frame unless its length is zero, and always owes an ACK.
               frame_left = data;
               ack_owed = 1'b1;
               if (data == 8'd0) res.kind = KIND_EMPTY;
               else frame_open = 1'b1;
               if (msg_left == 8'd0 || msg_refused) flush_ack();
            end else begin
               res.kind = KIND_PAYLOAD;
               res.data_out = data;
               if (frame_left <= 8'd1) begin
                  res.frame_end = 1'b1;
                  frame_left = 8'd0;
                  frame_open = 1'b0;
               end else begin
                  frame_left = frame_left - 8'd1;
               end
            end
         end
         ACT_HOST_BYTE: begin
            if (first) begin
               // A new message closes any unfinished one, then is judged whole.
               msg_left = 8'd0;
               msg_refused = 1'b0;
               flush_ack();
               res.kind = KIND_STATUS;
               if (len == 8'd0) begin
                  res.status = PUSH_BAD_LEN;
               end else if (len > ring_room()) begin
                  res.status = PUSH_OVERFLOW;
                  msg_left = len - 8'd1;
                  msg_refused = (msg_left != 8'd0);
               end else begin
                  ring_push(data);
                  msg_left = len - 8'd1;
                  if (msg_left == 8'd0) flush_ack();
               end
            end else if (msg_left != 8'd0) begin
               msg_left = msg_left - 8'd1;
               if (msg_refused) begin
                  if (msg_left == 8'd0) msg_refused = 1'b0;
               end else begin
                  ring_push(data);
                  if (msg_left == 8'd0) flush_ack();
               end
            end
         end
         ACT_TX_TICK: begin
            if (ring_wr != ring_rd) begin
               res.kind = KIND_TX_BYTE;
               res.data_out = tx_ring[ring_rd];
               ring_rd = ring_rd + 6'd1;
            end else begin
               res.kind = KIND_TX_IDLE;
            end
         end
         default: ;
      endcase
      awaited_results.push_back(res);
   endtask

   // Offer one item, with random idle cycles ahead of it, until it transfers.
   task automatic send_item(input logic [1:0] action, input logic [7:0] data,
                            input logic first, input logic [7:0] len);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {len, data};
      req_tuser <= {first, action};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_link_result(action, data, first, len);
   endtask

   // Stop offering items until every owed result has come back.
   task automatic hold_until_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (awaited_results.size() != 0) @(posedge clock);
   endtask

   // Receiver side: accept results with the current stall rate.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Compare each result transfer with the oldest prediction.
   always @(posedge clock) begin
      link_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_results.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual kind %0d data %02h",
                     $time, rsp_tuser, rsp_tdata[7:0]);
            error_count++;
         end else begin
            want = awaited_results.pop_front();
            if (rsp_tuser !== want.kind) begin
               $display("%0t: result_kind: expected %0d, actual %0d",
                        $time, want.kind, rsp_tuser);
               error_count++;
            end
            if (rsp_tdata[7:0] !== want.data_out) begin
               $display("%0t: byte_out: expected %02h, actual %02h",
                        $time, want.data_out, rsp_tdata[7:0]);
               error_count++;
            end
            if (rsp_tlast !== want.frame_end) begin
               $display("%0t: frame_last: expected %0d, actual %0d",
                        $time, want.frame_end, rsp_tlast);
               error_count++;
            end
            if (rsp_tdata[9:8] !== want.status) begin
               $display("%0t: push_status: expected %0d, actual %0d",
                        $time, want.status, rsp_tdata[9:8]);
               error_count++;
            end
         end
      end
   end

   // Framing and ring corner cases, one by one.
   task automatic test_directed_cases();
      send_item(ACT_TX_TICK,   8'h00, 1'b0, 8'h00);   // empty ring reports idle
      send_item(ACT_UNUSED,    8'hFF, 1'b1, 8'hFF);   // undefined action is ignored
      send_item(ACT_HOST_BYTE, 8'h5A, 1'b0, 8'h10);   // stray host byte, no message open
      send_item(ACT_RX_BYTE,   8'h00, 1'b1, 8'hFF);   // zero-length header ends at once
      send_item(ACT_RX_BYTE,   8'h02, 1'b0, 8'h00);   // header for two payload bytes
      send_item(ACT_RX_BYTE,   8'h00, 1'b0, 8'h00);
      send_item(ACT_RX_BYTE,   8'hFF, 1'b0, 8'h00);   // final payload byte
      send_item(ACT_HOST_BYTE, 8'h11, 1'b1, 8'h00);   // message length zero is refused
      send_item(ACT_HOST_BYTE, 8'hFF, 1'b1, 8'h03);   // three-byte message admitted
      send_item(ACT_RX_BYTE,   8'h01, 1'b0, 8'h00);   // ACK deferred behind the message
      send_item(ACT_RX_BYTE,   8'hAA, 1'b0, 8'h00);
      send_item(ACT_RX_BYTE,   8'h00, 1'b0, 8'h00);   // second header, ACK not doubled
      send_item(ACT_HOST_BYTE, 8'h01, 1'b0, 8'hEE);   // continuation is written
      send_item(ACT_HOST_BYTE, 8'h02, 1'b1, 8'hC8);   // cuts the message short, overflows
      send_item(ACT_HOST_BYTE, 8'h03, 1'b0, 8'h00);   // swallowed byte of refused message
      send_item(ACT_RX_BYTE,   8'h00, 1'b0, 8'h00);   // refused message does not defer ACK
      send_item(ACT_HOST_BYTE, 8'h04, 1'b1, 8'hFF);   // largest length, overflows
      for (int i = 0; i < 6; i++) send_item(ACT_TX_TICK, 8'h00, 1'b1, 8'h00);
      hold_until_drained();
   endtask

   // Interleaved well-formed frames and host messages, some noise.
   task automatic random_traffic(input int count, input int tick_pct);
      int r;
      int sent;
      logic [7:0] len;
      sent = 0;
      while (sent < count) begin
         r = $urandom_range(99);
         if (r < tick_pct) begin
            send_item(ACT_TX_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)),
                      8'($urandom_range(255)));
            sent++;
         end else if (r < tick_pct + (100 - tick_pct) / 2) begin
            if (gen_frame_left == 8'd0) begin
               r = $urandom_range(99);
               if (r < 10) len = 8'd0;
               else if (r < 88) len = 8'($urandom_range(1, 8));
               else if (r < 98) len = 8'($urandom_range(9, 40));
               else len = 8'($urandom_range(41, 255));
               gen_frame_left = len;
            end else begin
               len = 8'($urandom_range(255));
               gen_frame_left = gen_frame_left - 8'd1;
            end
            send_item(ACT_RX_BYTE, len, 1'($urandom_range(1)), 8'($urandom_range(255)));
            sent++;
         end else if (r < 96) begin
            if (gen_msg_left == 8'd0 || $urandom_range(19) == 0) begin
               r = $urandom_range(99);
               if (r < 5) len = 8'd0;
               else if (r < 75) len = 8'($urandom_range(1, 12));
               else if (r < 93) len = 8'($urandom_range(13, 63));
               else len = 8'($urandom_range(64, 255));
               gen_msg_left = (len == 8'd0) ? 8'd0 : len - 8'd1;
               send_item(ACT_HOST_BYTE, 8'($urandom_range(255)), 1'b1, len);
            end else begin
               gen_msg_left = gen_msg_left - 8'd1;
               send_item(ACT_HOST_BYTE, 8'($urandom_range(255)), 1'b0,
                         8'($urandom_range(255)));
            end
            sent++;
         end else if (r < 99) begin
            send_item(ACT_HOST_BYTE, 8'($urandom_range(255)), 1'b0, 8'($urandom_range(255)));
         end else begin
            send_item(ACT_UNUSED, 8'($urandom_range(255)), 1'($urandom_range(1)),
                      8'($urandom_range(255)));
         end
      end
   endtask

   task automatic test_stream_no_idle();
      sender_idle_pct = 0;
      rsp_stall_pct = 0;
      random_traffic(150, 30);
      random_traffic(150, 60);
   endtask

   task automatic test_sender_gaps();
      sender_idle_pct = 88;
      rsp_stall_pct = 0;
      random_traffic(150, 30);
      random_traffic(150, 60);
   endtask

   task automatic test_receiver_stalls();
      sender_idle_pct = 0;
      rsp_stall_pct = 88;
      random_traffic(150, 60);
      hold_until_drained();
      random_traffic(150, 30);
   endtask

   task automatic test_both_idle();
      sender_idle_pct = 32;
      rsp_stall_pct = 32;
      random_traffic(150, 30);
      random_traffic(150, 60);
   endtask

   initial begin
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= '0;
      ring_wr = '0;
      ring_rd = '0;
      frame_open = 1'b0;
      frame_left = '0;
      ack_owed = 1'b0;
      msg_left = '0;
      msg_refused = 1'b0;
      for (int i = 0; i < RING_SLOTS; i++) tx_ring[i] = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_stream_no_idle();
      test_sender_gaps();
      test_receiver_stalls();
      test_both_idle();

      // Let the last results out, then wait for any stray ones.
      hold_until_drained();
      repeat (30) @(posedge clock);
      if (error_count == 0 && awaited_results.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #10_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
